// ----- rtl/tksq_pkg.sv -----
// Shared types and constants for the two-key sorted priority queue.
// Holds command and status codes, the entry layout and the cell control word.
// Depends on nothing; tksq_cell and the top level import it.
package tksq_pkg;

	localparam int unsigned CAPACITY_DEF = 64;
	localparam int unsigned COORD_W      = 15;
	localparam int unsigned VTX_W        = 2 * COORD_W;
	localparam int unsigned HALF_W       = 32;
	localparam int unsigned KEY_W        = 2 * HALF_W;
	localparam int unsigned COUNT_OUT_W  = 7;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_UPDATE = 2'd2,
		CMD_QUERY  = 2'd3
	} command_t;

	typedef enum logic [1:0] {
		STATUS_DONE      = 2'd0,
		STATUS_FULL      = 2'd1,
		STATUS_NOT_FOUND = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_MATCH  = 2'd1,
		CELL_INSERT = 2'd2,
		CELL_DROP   = 2'd3
	} cell_op_t;

	// Key is primary in the high half, secondary in the low half, so a plain
	// unsigned compare gives the lexicographic order.
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [VTX_W-1:0] vtx;
	} entry_t;

	typedef struct packed {
		cell_op_t op;
		entry_t   ins;
	} cell_ctl_t;

endpackage

// ----- rtl/tksq_ifs.sv -----
// Valid/ready channel interfaces for the command and response beats.
// Depends on nothing; field widths follow the block's fixed item format.
interface tksq_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [14:0] vertex_x;
	logic [14:0] vertex_y;
	logic [31:0] key_primary;
	logic [31:0] key_secondary;

	modport source (output valid, command, vertex_x, vertex_y, key_primary, key_secondary,
		input ready);
	modport sink (input valid, command, vertex_x, vertex_y, key_primary, key_secondary,
		output ready);
endinterface

interface tksq_rsp_if;
	logic        valid;
	logic        ready;
	logic [14:0] head_x;
	logic [14:0] head_y;
	logic [31:0] head_primary;
	logic [31:0] head_secondary;
	logic [6:0]  entry_count;
	logic [1:0]  status;

	modport source (output valid, head_x, head_y, head_primary, head_secondary, entry_count,
		status, input ready);
	modport sink (input valid, head_x, head_y, head_primary, head_secondary, entry_count,
		status, output ready);
endinterface

// ----- rtl/tksq_cell.sv -----
// One cell of the sorted chain: holds a single entry and trades it with its neighbors.
// Depends on tksq_pkg for the entry layout and the control word.
module tksq_cell
	import tksq_pkg::*;
(
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  logic      valid,
	input  entry_t    left,
	input  logic      left_place,
	input  entry_t    right,
	input  logic      drop_sel,
	output entry_t    entry,
	output logic      place,
	output logic      match
);

	entry_t entry_q;
	logic   match_q;

	// The list is sorted, so place is a suffix over the chain: the new entry
	// lands in the first cell that raises it, and later cells shift right.
	assign place = !valid || (entry_q.key > ctl.ins.key);

	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_MATCH: begin
				match_q <= valid && (entry_q.vtx == ctl.ins.vtx);
			end
			CELL_INSERT: begin
				if (place) begin
					entry_q <= left_place ? left : ctl.ins;
				end
			end
			CELL_DROP: begin
				if (drop_sel) begin
					entry_q <= right;
				end
			end
			default: begin
			end
		endcase
	end

	assign entry = entry_q;
	assign match = match_q;

endmodule

// ----- rtl/two_key_sorted_priority_queue.sv -----
// Two-key sorted priority queue: top level with sequencer, cell chain and response register.
// Depends on tksq_pkg, the channel interfaces in tksq_ifs.sv and tksq_cell.
//
// Usage: each command beat (insert, remove, update key, query) on cmd gives
// exactly one response beat on rsp, carrying the head entry, the entry count
// after the command and a status. The list is a row of CAPACITY cells; every
// cell compares its own entry at once, so the whole list shifts together.
// The sequencer takes one command at a time. From accept to the response
// register, a query goes straight to the load, an insert places first, a
// remove matches and closes up, and an update matches, closes up and then
// opens and places before the response is loaded. A new command is taken
// in the cycle after the response is loaded, not before.
// While the receiver stalls, the response waits in its register, the next
// command is still accepted and worked on, and its response is held back
// until the register frees. Reset empties the list at once (count to zero,
// no clearing pass) and leaves no response pending.
module two_key_sorted_priority_queue
	import tksq_pkg::*;
#(
	parameter int unsigned CAPACITY = CAPACITY_DEF
) (
	input  logic clk,
	input  logic arst_n,
	tksq_cmd_if.sink   cmd,
	tksq_rsp_if.source rsp
);

	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned LV = $clog2(CAPACITY);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_MATCH  = 5'b00010,
		ST_DROP   = 5'b00100,
		ST_INSERT = 5'b01000,
		ST_RESP   = 5'b10000
	} state_t;

	state_t   state_q;
	command_t cmd_q;
	status_t  status_q;
	entry_t   ins_q;
	logic [CW-1:0] count_q;

	logic                rsp_valid_q;
	logic [COORD_W-1:0]  head_x_q;
	logic [COORD_W-1:0]  head_y_q;
	logic [HALF_W-1:0]   head_primary_q;
	logic [HALF_W-1:0]   head_secondary_q;
	logic [CW-1:0]       head_count_q;
	status_t             head_status_q;

	cell_ctl_t            ctl;
	entry_t               ent [CAPACITY];
	logic [CAPACITY-1:0]  valid;
	logic [CAPACITY-1:0]  place;
	logic [CAPACITY-1:0]  match;
	logic [CAPACITY-1:0]  pfx [LV+1];
	logic                 found;
	logic                 full;
	logic                 cmd_fire;
	logic                 rsp_free;

	assign cmd_fire = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == ST_IDLE);
	assign rsp_free = !rsp_valid_q || rsp.ready;
	assign full = (count_q == CW'(CAPACITY));

	// A prefix OR over the registered match bits marks the first match and
	// every cell after it; those cells take their right neighbor's entry.
	assign pfx[0] = match;
	for (genvar l = 0; l < LV; l++) begin : g_pfx
		for (genvar i = 0; i < CAPACITY; i++) begin : g_bit
			if (i >= (1 << l)) begin : g_or
				assign pfx[l+1][i] = pfx[l][i] | pfx[l][i - (1 << l)];
			end else begin : g_pass
				assign pfx[l+1][i] = pfx[l][i];
			end
		end
	end
	assign found = pfx[LV][CAPACITY-1];

	always_comb begin
		ctl.ins = ins_q;
		case (state_q)
			ST_MATCH:  ctl.op = CELL_MATCH;
			ST_DROP:   ctl.op = found ? CELL_DROP : CELL_HOLD;
			ST_INSERT: ctl.op = CELL_INSERT;
			default:   ctl.op = CELL_HOLD;
		endcase
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		entry_t left_ent;
		entry_t right_ent;
		logic   left_pl;

		assign valid[i] = (count_q > CW'(i));

		if (i == 0) begin : g_first
			assign left_ent = ins_q;
			assign left_pl  = 1'b0;
		end else begin : g_inner_l
			assign left_ent = ent[i-1];
			assign left_pl  = place[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_ent = '0;
		end else begin : g_inner_r
			assign right_ent = ent[i+1];
		end

		tksq_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.valid      (valid[i]),
			.left       (left_ent),
			.left_place (left_pl),
			.right      (right_ent),
			.drop_sel   (pfx[LV][i]),
			.entry      (ent[i]),
			.place      (place[i]),
			.match      (match[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			cmd_q    <= CMD_QUERY;
			status_q <= STATUS_DONE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_fire) begin
						cmd_q    <= command_t'(cmd.command);
						status_q <= STATUS_DONE;
						case (command_t'(cmd.command))
							CMD_INSERT: begin
								if (full) begin
									status_q <= STATUS_FULL;
									state_q  <= ST_RESP;
								end else begin
									state_q <= ST_INSERT;
								end
							end
							CMD_REMOVE, CMD_UPDATE: state_q <= ST_MATCH;
							default: state_q <= ST_RESP;
						endcase
					end
				end
				ST_MATCH: begin
					state_q <= ST_DROP;
				end
				ST_DROP: begin
					if (found) begin
						count_q <= count_q - 1'b1;
						state_q <= (cmd_q == CMD_UPDATE) ? ST_INSERT : ST_RESP;
					end else begin
						status_q <= STATUS_NOT_FOUND;
						state_q  <= ST_RESP;
					end
				end
				ST_INSERT: begin
					count_q <= count_q + 1'b1;
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			ins_q.key <= {cmd.key_primary, cmd.key_secondary};
			ins_q.vtx <= {cmd.vertex_y, cmd.vertex_x};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_RESP && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESP && rsp_free) begin
			head_count_q  <= count_q;
			head_status_q <= status_q;
			if (valid[0]) begin
				head_x_q         <= ent[0].vtx[COORD_W-1:0];
				head_y_q         <= ent[0].vtx[VTX_W-1:COORD_W];
				head_primary_q   <= ent[0].key[KEY_W-1:HALF_W];
				head_secondary_q <= ent[0].key[HALF_W-1:0];
			end else begin
				head_x_q         <= '0;
				head_y_q         <= '0;
				head_primary_q   <= '1;
				head_secondary_q <= '1;
			end
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.head_x         = head_x_q;
	assign rsp.head_y         = head_y_q;
	assign rsp.head_primary   = head_primary_q;
	assign rsp.head_secondary = head_secondary_q;
	assign rsp.entry_count    = COUNT_OUT_W'(head_count_q);
	assign rsp.status         = head_status_q;

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count exceeds capacity");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INSERT) |-> !full)
		else $error("insert started on a full list");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DROP && found) |=> (count_q == $past(count_q) - 1'b1))
		else $error("entry count not reduced after a close-up");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESP && !rsp_free) |=> (state_q == ST_RESP))
		else $error("response state left while the response register was busy");
`endif

endmodule
